>>> rtl/tricc_pkg.sv
// shared types and constants for the triangle circumcircle block
package tricc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 48;

  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] bx;
    logic signed [IN_W-1:0] by_coord;
    logic signed [IN_W-1:0] cx;
    logic signed [IN_W-1:0] cy;
  } tri_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic        [OUT_W-1:0] radius;
    logic                    degenerate;
  } circ_out_t;

endpackage

>>> rtl/triangle_circumcircle.sv
// triangle circumcircle: fully pipelined centre and radius of the circle through three points
//
// usage
//   input beat: in_tri holds the three vertices; a beat is taken at a rising edge with
//   start high and busy low. busy is high during reset and is cleared by the first clock edge
//   after reset is released, then stays low, so one triangle can be taken every clock.
//   result beat: out_valid is high for exactly one cycle with out_circ (centre x and y and
//   radius in Q(48-FRAC_BITS).FRAC_BITS, truncated and saturated, plus the degenerate flag); there is
//   no back pressure, the receiver must take each result when it is shown.
//   results leave in input order.
//   throughput: one triangle per clock; the pipeline length is set by the bit-serial chain of
//   compare/subtract stages (two centre dividers beside the square root, then the radius
//   divider), one quotient or root bit per stage.
//   collinear vertices give degenerate = 1 with all other fields zero.
//   reset: synchronous, active low; clears every valid bit, so beats in flight are dropped.
module triangle_circumcircle #(
  parameter int COORD_BITS = tricc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tricc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tricc_pkg::tri_in_t   in_tri,
  output logic                 out_valid,
  output tricc_pkg::circ_out_t out_circ
);

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int OW   = tricc_pkg::OUT_W;
  localparam int EXW  = (CB > tricc_pkg::IN_W) ? CB : tricc_pkg::IN_W;
  localparam int DW   = CB + 1;          // vertex differences
  localparam int PRW  = 2 * DW;          // difference products
  localparam int LW   = 2 * CB + 1;      // squared side lengths
  localparam int DDW  = 2 * CB + 3;      // 2D, signed
  localparam int MW   = 2 * CB + 2;      // |2D|
  localparam int XW   = 3 * CB + 4;      // centre numerators, signed
  localparam int NW   = 3 * CB + 3 + FB; // centre dividend and quotient
  localparam int LH   = (LW + 1) / 2;
  localparam int LHI  = LW - LH;
  localparam int QW   = 2 * LW;
  localparam int QH   = QW / 2;
  localparam int QHI  = QW - QH;
  localparam int PW   = 3 * LW;          // product of the three squared sides
  localparam int SW   = 3 * CB + 2 + FB; // root width
  localparam int SIW  = 2 * SW;          // radicand width
  localparam int TOT  = NW + SW;         // bit-serial stages
  localparam int LAT  = TOT + 8;
  localparam int CW   = ((NW > OW) ? NW : OW) + 1;
  localparam int RCW  = ((SW > OW) ? SW : OW) + 1;

  function automatic logic signed [CB-1:0] sx(input logic signed [tricc_pkg::IN_W-1:0] f);
    logic signed [EXW-1:0] e;
    e = EXW'(f);
    return e[CB-1:0];
  endfunction

  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // stage 1: sign extend and take differences relative to vertex a, plus the side from b to c
  logic signed [CB-1:0] ax_nxt, ay_nxt, bx_s, by_s, cx_s, cy_s;
  logic signed [DW-1:0] bxr_nxt, byr_nxt, cxr_nxt, cyr_nxt, ex_nxt, ey_nxt;

  always_comb begin
    ax_nxt  = sx(in_tri.ax);
    ay_nxt  = sx(in_tri.ay);
    bx_s    = sx(in_tri.bx);
    by_s    = sx(in_tri.by_coord);
    cx_s    = sx(in_tri.cx);
    cy_s    = sx(in_tri.cy);
    bxr_nxt = DW'(bx_s) - DW'(ax_nxt);
    byr_nxt = DW'(by_s) - DW'(ay_nxt);
    cxr_nxt = DW'(cx_s) - DW'(ax_nxt);
    cyr_nxt = DW'(cy_s) - DW'(ay_nxt);
    ex_nxt  = DW'(cx_s) - DW'(bx_s);
    ey_nxt  = DW'(cy_s) - DW'(by_s);
  end

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [CB-1:0] ax1_r, ay1_r, ax2_r, ay2_r, ax3_r, ay3_r;
  logic signed [DW-1:0] bxr1_r, byr1_r, cxr1_r, cyr1_r, ex1_r, ey1_r;
  logic signed [DW-1:0] bxr2_r, byr2_r, cxr2_r, cyr2_r;
  logic signed [DW-1:0] bxr3_r, byr3_r, cxr3_r, cyr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    ax1_r  <= ax_nxt;
    ay1_r  <= ay_nxt;
    bxr1_r <= bxr_nxt;
    byr1_r <= byr_nxt;
    cxr1_r <= cxr_nxt;
    cyr1_r <= cyr_nxt;
    ex1_r  <= ex_nxt;
    ey1_r  <= ey_nxt;
  end

  // stage 2: cross products and squares
  logic signed [PRW-1:0] pbc_r, pcb_r, sbx_r, sby_r, scx_r, scy_r, sex_r, sey_r;

  always_ff @(posedge clk) begin
    pbc_r  <= bxr1_r * cyr1_r;
    pcb_r  <= cxr1_r * byr1_r;
    sbx_r  <= bxr1_r * bxr1_r;
    sby_r  <= byr1_r * byr1_r;
    scx_r  <= cxr1_r * cxr1_r;
    scy_r  <= cyr1_r * cyr1_r;
    sex_r  <= ex1_r * ex1_r;
    sey_r  <= ey1_r * ey1_r;
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    bxr2_r <= bxr1_r;
    byr2_r <= byr1_r;
    cxr2_r <= cxr1_r;
    cyr2_r <= cyr1_r;
  end

  // stage 3: 2D, squared side lengths and the collinear flag
  logic signed [DDW-1:0] d2_nxt, d2_r, d24_r, d25_r;
  logic [LW-1:0] lb_r, lc_r, lbc_r, lc4_r, lc5_r;
  logic dg3_r, dg4_r, dg5_r, dg6_r;

  assign d2_nxt = (DDW'(pbc_r) - DDW'(pcb_r)) <<< 1;

  always_ff @(posedge clk) begin
    d2_r   <= d2_nxt;
    lb_r   <= sbx_r[LW-1:0] + sby_r[LW-1:0];
    lc_r   <= scx_r[LW-1:0] + scy_r[LW-1:0];
    lbc_r  <= sex_r[LW-1:0] + sey_r[LW-1:0];
    dg3_r  <= (pbc_r == pcb_r);
    ax3_r  <= ax2_r;
    ay3_r  <= ay2_r;
    bxr3_r <= bxr2_r;
    byr3_r <= byr2_r;
    cxr3_r <= cxr2_r;
    cyr3_r <= cyr2_r;
  end

  // stage 4: numerator terms and first half of the side product
  logic signed [CB+DDW-1:0] tax_r, tay_r;
  logic signed [DW+LW:0]    tcl_r, tbl_r, tbc_r, tcb_r;
  logic [LW+LH-1:0]         mlo_r;
  logic [LW+LHI-1:0]        mhi_r;

  always_ff @(posedge clk) begin
    tax_r <= ax3_r * d2_r;
    tay_r <= ay3_r * d2_r;
    tcl_r <= cyr3_r * signed'({1'b0, lb_r});
    tbl_r <= byr3_r * signed'({1'b0, lc_r});
    tbc_r <= bxr3_r * signed'({1'b0, lc_r});
    tcb_r <= cxr3_r * signed'({1'b0, lb_r});
    mlo_r <= lb_r * lbc_r[LH-1:0];
    mhi_r <= lb_r * lbc_r[LW-1:LH];
    d24_r <= d2_r;
    lc4_r <= lc_r;
    dg4_r <= dg3_r;
  end

  // stage 5: sum the numerators and combine the partial side products
  logic signed [XW-1:0] xn_r, yn_r;
  logic [QW-1:0] q_r;

  always_ff @(posedge clk) begin
    xn_r  <= XW'(tax_r) + XW'(tcl_r) - XW'(tbl_r);
    yn_r  <= XW'(tay_r) + XW'(tbc_r) - XW'(tcb_r);
    q_r   <= QW'(mlo_r) + (QW'(mhi_r) << LH);
    d25_r <= d24_r;
    lc5_r <= lc4_r;
    dg5_r <= dg4_r;
  end

  // stage 6: magnitudes, quotient signs, second half of the side product
  logic [XW-2:0] nx_r, ny_r;
  logic negx6_r, negy6_r;
  logic [MW-1:0] den6_r;
  logic [QH+LW-1:0]  plo_r;
  logic [QHI+LW-1:0] phi_r;

  always_ff @(posedge clk) begin
    nx_r    <= xn_r[XW-1] ? (XW-1)'(-xn_r) : (XW-1)'(xn_r);
    ny_r    <= yn_r[XW-1] ? (XW-1)'(-yn_r) : (XW-1)'(yn_r);
    negx6_r <= xn_r[XW-1] ^ d25_r[DDW-1];
    negy6_r <= yn_r[XW-1] ^ d25_r[DDW-1];
    den6_r  <= d25_r[DDW-1] ? MW'(-d25_r) : MW'(d25_r);
    plo_r   <= q_r[QH-1:0] * lc5_r;
    phi_r   <= q_r[QW-1:QH] * lc5_r;
    dg6_r   <= dg5_r;
  end

  logic [PW-1:0] psum_nxt;
  assign psum_nxt = PW'(plo_r) + (PW'(phi_r) << QH);

  // bit-serial chain: index 0 is the entry register, index TOT the last stage
  logic              v_r    [0:TOT];
  logic              dg_r   [0:TOT];
  logic              negx_r [0:TOT];
  logic              negy_r [0:TOT];
  logic [MW-1:0]     den_r  [0:TOT];
  logic [NW-1:0]     numx_r [0:TOT];
  logic [NW-1:0]     numy_r [0:TOT];
  logic [MW-1:0]     remx_r [0:TOT];
  logic [MW-1:0]     remy_r [0:TOT];
  logic [NW-1:0]     qx_r   [0:TOT];
  logic [NW-1:0]     qy_r   [0:TOT];
  logic [SIW-1:0]    rad_r  [0:TOT];
  logic [SW:0]       rs_r   [0:TOT];
  logic [SW-1:0]     root_r [0:TOT];
  logic [MW-1:0]     rr_r   [0:TOT];
  logic [SW-1:0]     qr_r   [0:TOT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    dg_r[0]   <= dg6_r;
    negx_r[0] <= negx6_r;
    negy_r[0] <= negy6_r;
    den_r[0]  <= den6_r;
    numx_r[0] <= NW'(nx_r) << FB;
    numy_r[0] <= NW'(ny_r) << FB;
    remx_r[0] <= '0;
    remy_r[0] <= '0;
    qx_r[0]   <= '0;
    qy_r[0]   <= '0;
    rad_r[0]  <= SIW'(psum_nxt) << (2 * FB);
    rs_r[0]   <= '0;
    root_r[0] <= '0;
    rr_r[0]   <= '0;
    qr_r[0]   <= '0;
  end

  for (genvar s = 0; s < TOT; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      dg_r[s+1]   <= dg_r[s];
      negx_r[s+1] <= negx_r[s];
      negy_r[s+1] <= negy_r[s];
      den_r[s+1]  <= den_r[s];
      numx_r[s+1] <= numx_r[s];
      numy_r[s+1] <= numy_r[s];
      rad_r[s+1]  <= rad_r[s];
    end

    // centre dividers, one quotient bit each
    if (s < NW) begin : g_cdiv
      logic [MW:0] rx, ry;
      logic gx, gy;
      always_comb begin
        rx = {remx_r[s], numx_r[s][NW-1-s]};
        ry = {remy_r[s], numy_r[s][NW-1-s]};
        gx = (rx >= {1'b0, den_r[s]});
        gy = (ry >= {1'b0, den_r[s]});
      end
      always_ff @(posedge clk) begin
        remx_r[s+1] <= gx ? MW'(rx - {1'b0, den_r[s]}) : rx[MW-1:0];
        remy_r[s+1] <= gy ? MW'(ry - {1'b0, den_r[s]}) : ry[MW-1:0];
        qx_r[s+1]   <= {qx_r[s][NW-2:0], gx};
        qy_r[s+1]   <= {qy_r[s][NW-2:0], gy};
      end
    end else begin : g_chold
      always_ff @(posedge clk) begin
        remx_r[s+1] <= remx_r[s];
        remy_r[s+1] <= remy_r[s];
        qx_r[s+1]   <= qx_r[s];
        qy_r[s+1]   <= qy_r[s];
      end
    end

    // square root of the scaled side product, one root bit each
    if (s < SW) begin : g_sqrt
      logic [SW+1:0] rq, trial;
      logic gs;
      always_comb begin
        rq    = {rs_r[s][SW-1:0], rad_r[s][2*(SW-1-s)+1 -: 2]};
        trial = {root_r[s], 2'b01};
        gs    = (rq >= trial);
      end
      always_ff @(posedge clk) begin
        rs_r[s+1]   <= gs ? (SW+1)'(rq - trial) : (SW+1)'(rq);
        root_r[s+1] <= {root_r[s][SW-2:0], gs};
      end
    end else begin : g_shold
      always_ff @(posedge clk) begin
        rs_r[s+1]   <= rs_r[s];
        root_r[s+1] <= root_r[s];
      end
    end

    // radius divider: root over |2D|
    if (s >= NW) begin : g_rdiv
      logic [MW:0] rd;
      logic gr;
      always_comb begin
        rd = {rr_r[s], root_r[s][SW-1-(s-NW)]};
        gr = (rd >= {1'b0, den_r[s]});
      end
      always_ff @(posedge clk) begin
        rr_r[s+1] <= gr ? MW'(rd - {1'b0, den_r[s]}) : rd[MW-1:0];
        qr_r[s+1] <= {qr_r[s][SW-2:0], gr};
      end
    end else begin : g_rhold
      always_ff @(posedge clk) begin
        rr_r[s+1] <= rr_r[s];
        qr_r[s+1] <= qr_r[s];
      end
    end
  end

  // saturate, restore signs, zero a collinear result
  tricc_pkg::circ_out_t out_nxt, out_r;
  logic out_v_r;

  always_comb begin
    logic [CW-1:0]  wqx, wqy, capx, capy;
    logic [RCW-1:0] wqr, capr;
    logic [OW-1:0]  mx, my;
    wqx  = CW'(qx_r[TOT]);
    wqy  = CW'(qy_r[TOT]);
    capx = negx_r[TOT] ? (CW'(1) << (OW - 1)) : ((CW'(1) << (OW - 1)) - CW'(1));
    capy = negy_r[TOT] ? (CW'(1) << (OW - 1)) : ((CW'(1) << (OW - 1)) - CW'(1));
    wqr  = RCW'(qr_r[TOT]);
    capr = (RCW'(1) << OW) - RCW'(1);
    mx   = (wqx > capx) ? capx[OW-1:0] : wqx[OW-1:0];
    my   = (wqy > capy) ? capy[OW-1:0] : wqy[OW-1:0];
    if (dg_r[TOT]) begin
      out_nxt.center_x   = '0;
      out_nxt.center_y   = '0;
      out_nxt.radius     = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.center_x   = negx_r[TOT] ? -mx : mx;
      out_nxt.center_y   = negy_r[TOT] ? -my : my;
      out_nxt.radius     = (wqr > capr) ? capr[OW-1:0] : wqr[OW-1:0];
      out_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= v_r[TOT];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_circ  = out_r;

  // every result beat traces back to an accepted input beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result beat without a matching input beat");

  a_chain_valid: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NW] |-> $past(v_r[0], NW))
    else $error("valid bit lost or created in the centre dividers");

  a_cdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NW] && !dg_r[NW]) |-> (remx_r[NW] < den_r[NW] && remy_r[NW] < den_r[NW]))
    else $error("centre divider remainder not below the divisor");

  a_rdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[TOT] && !dg_r[TOT]) |-> (rr_r[TOT] < den_r[TOT]))
    else $error("radius divider remainder not below the divisor");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_circ.degenerate) |->
      (out_circ.center_x == '0 && out_circ.center_y == '0 && out_circ.radius == '0))
    else $error("collinear result carries nonzero fields");

endmodule
